// ===== sv/slex_pkg.sv =====
// shared types, constants and helpers for the source lexer
`default_nettype none
package slex_pkg;

  localparam int OFFSET_WIDTH = 32;
  localparam int LINE_WIDTH   = 32;
  localparam int LENGTH_WIDTH = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [4:0] K_IDENT   = 5'd0;
  localparam logic [4:0] K_INT     = 5'd1;
  localparam logic [4:0] K_FLOAT   = 5'd2;
  localparam logic [4:0] K_RETURN  = 5'd3;
  localparam logic [4:0] K_LET     = 5'd4;
  localparam logic [4:0] K_FN      = 5'd5;
  localparam logic [4:0] K_EXTERN  = 5'd6;
  localparam logic [4:0] K_BUILTIN = 5'd7;
  localparam logic [4:0] K_LPAREN  = 5'd8;
  localparam logic [4:0] K_RPAREN  = 5'd9;
  localparam logic [4:0] K_LBRACE  = 5'd10;
  localparam logic [4:0] K_RBRACE  = 5'd11;
  localparam logic [4:0] K_COLON   = 5'd12;
  localparam logic [4:0] K_SEMI    = 5'd13;
  localparam logic [4:0] K_ASSIGN  = 5'd14;
  localparam logic [4:0] K_EQEQ    = 5'd15;
  localparam logic [4:0] K_PLUS    = 5'd16;
  localparam logic [4:0] K_MINUS   = 5'd17;
  localparam logic [4:0] K_ARROW   = 5'd18;
  localparam logic [4:0] K_STAR    = 5'd19;
  localparam logic [4:0] K_SLASH   = 5'd20;
  localparam logic [4:0] K_PCT     = 5'd21;
  localparam logic [4:0] K_ELLIPS  = 5'd22;
  localparam logic [4:0] K_COMMA   = 5'd23;
  localparam logic [4:0] K_END     = 5'd24;

  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_NODIG  = 2'd1;
  localparam logic [1:0] E_SYMBOL = 2'd2;
  localparam logic [1:0] E_CHAR   = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_INT, M_INTDOT, M_FRAC, M_SLASH, M_LINECMT,
    M_BLOCK, M_BLOCKSTAR, M_MINUS, M_EQ, M_DOT1, M_DOT2
  } mode_t;

  // one result word
  typedef struct packed {
    logic [4:0]              kind;
    logic [3:0]              btype;
    logic [OFFSET_WIDTH-1:0] start;
    logic [LENGTH_WIDTH-1:0] len;
    logic [LINE_WIDTH-1:0]   line;
    logic [1:0]              err;
    logic                    fin;
  } tok_t;

  // up to three results made by one character
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } group_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage
`default_nettype wire

// ===== sv/slex_front.sv =====
// front end: mode machine that classifies characters into result groups
`default_nettype none
module slex_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire logic [7:0]      c,
  input  wire logic            last,
  output slex_pkg::group_t     grp
);
  import slex_pkg::*;

  mode_t                   mode_r, mode_nxt;
  logic [OFFSET_WIDTH-1:0] off_r, off_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;
  logic [OFFSET_WIDTH-1:0] tstart_r, tstart_nxt;
  logic [LENGTH_WIDTH-1:0] tlen_r, tlen_nxt;
  logic [47:0]             pfx_r, pfx_nxt;
  logic                    halt_r, halt_nxt;

  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

  function automatic logic [LENGTH_WIDTH-1:0] linc(input logic [LENGTH_WIDTH-1:0] n);
    return (n == LEN_MAX) ? n : n + 1'b1;
  endfunction

  // keyword and builtin lookup on the six-byte prefix
  function automatic logic [8:0] kw(input logic [47:0] p, input logic [LENGTH_WIDTH-1:0] n);
    logic [8:0] r;
    r = {K_IDENT, 4'd0};
    case (n)
      LENGTH_WIDTH'(2): begin
        if (p[15:0] == "fn") r = {K_FN, 4'd0};
        else if (p[15:0] == "i8") r = {K_BUILTIN, 4'd1};
        else if (p[15:0] == "u8") r = {K_BUILTIN, 4'd6};
      end
      LENGTH_WIDTH'(3): begin
        case (p[23:0])
          "let": r = {K_LET, 4'd0};
          "i16": r = {K_BUILTIN, 4'd2};
          "i32": r = {K_BUILTIN, 4'd3};
          "i64": r = {K_BUILTIN, 4'd4};
          "u16": r = {K_BUILTIN, 4'd7};
          "u32": r = {K_BUILTIN, 4'd8};
          "u64": r = {K_BUILTIN, 4'd9};
          "f32": r = {K_BUILTIN, 4'd11};
          "f64": r = {K_BUILTIN, 4'd12};
          default: r = {K_IDENT, 4'd0};
        endcase
      end
      LENGTH_WIDTH'(4): begin
        if (p[31:0] == "void") r = {K_BUILTIN, 4'd0};
        else if (p[31:0] == "i128") r = {K_BUILTIN, 4'd5};
        else if (p[31:0] == "u128") r = {K_BUILTIN, 4'd10};
      end
      LENGTH_WIDTH'(6): begin
        if (p == "return") r = {K_RETURN, 4'd0};
        else if (p == "extern") r = {K_EXTERN, 4'd0};
      end
      default: r = {K_IDENT, 4'd0};
    endcase
    return r;
  endfunction

  always_comb begin
    tok_t       t;
    tok_t       q [3];
    logic [1:0] n;
    logic       taken;
    logic       err;
    logic [4:0] k;
    logic [8:0] wk;
    logic [OFFSET_WIDTH-1:0] off_inc;

    mode_nxt   = mode_r;
    off_nxt    = off_r;
    line_nxt   = line_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    pfx_nxt    = pfx_r;
    halt_nxt   = halt_r;
    n     = 2'd0;
    taken = 1'b0;
    err   = 1'b0;
    k     = K_IDENT;
    wk    = kw(pfx_r, tlen_r);
    off_inc = off_r + 1'b1;
    t = '0;
    q[0] = '0; q[1] = '0; q[2] = '0;

    if (halt_r) begin
      if (last) begin
        halt_nxt = 1'b0;
        mode_nxt = M_IDLE; off_nxt = '0; line_nxt = LINE_WIDTH'(1);
        tstart_nxt = '0; tlen_nxt = '0; pfx_nxt = '0;
      end
    end else begin
      // held construct
      case (mode_r)
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (tlen_r < LENGTH_WIDTH'(6)) pfx_nxt = {pfx_r[39:0], c};
            tlen_nxt = linc(tlen_r); taken = 1'b1;
          end else begin
            t = '0; t.kind = wk[8:4]; t.btype = wk[3:0];
            t.start = tstart_r; t.len = tlen_r; t.line = line_r;
            q[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            tlen_nxt = linc(tlen_r); taken = 1'b1;
          end else if (c == ".") begin
            tlen_nxt = linc(tlen_r); mode_nxt = M_INTDOT; taken = 1'b1;
          end else begin
            t = '0; t.kind = K_INT; t.start = tstart_r; t.len = tlen_r; t.line = line_r;
            q[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_INTDOT: begin
          taken = 1'b1;
          if (is_digit(c)) begin
            tlen_nxt = linc(tlen_r); mode_nxt = M_FRAC;
          end else begin
            t = '0; t.start = tstart_r; t.len = tlen_r; t.line = line_r; t.err = E_NODIG;
            q[n] = t; n = n + 1'b1; err = 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            tlen_nxt = linc(tlen_r); taken = 1'b1;
          end else begin
            t = '0; t.kind = K_FLOAT; t.start = tstart_r; t.len = tlen_r; t.line = line_r;
            q[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_nxt = M_LINECMT; taken = 1'b1;
          end else if (c == "*") begin
            mode_nxt = M_BLOCKSTAR; taken = 1'b1;
          end else begin
            t = '0; t.kind = K_SLASH; t.start = tstart_r; t.len = tlen_r; t.line = line_r;
            q[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_LINECMT: begin
          taken = 1'b1;
          if (c == 8'h0a) begin
            line_nxt = line_r + 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_BLOCK, M_BLOCKSTAR: begin
          taken = 1'b1;
          if (mode_r == M_BLOCKSTAR && c == "/") mode_nxt = M_IDLE;
          else if (c == "*") mode_nxt = M_BLOCKSTAR;
          else begin
            if (c == 8'h0a) line_nxt = line_r + 1'b1;
            mode_nxt = M_BLOCK;
          end
        end
        M_MINUS, M_EQ: begin
          if ((mode_r == M_MINUS && c == ">") || (mode_r == M_EQ && c == "=")) begin
            t = '0; t.kind = (mode_r == M_MINUS) ? K_ARROW : K_EQEQ;
            t.start = tstart_r; t.len = LENGTH_WIDTH'(2); t.line = line_r;
            q[n] = t; n = n + 1'b1; mode_nxt = M_IDLE; taken = 1'b1;
          end else begin
            t = '0; t.kind = (mode_r == M_MINUS) ? K_MINUS : K_ASSIGN;
            t.start = tstart_r; t.len = tlen_r; t.line = line_r;
            q[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
          end
        end
        M_DOT1, M_DOT2: begin
          taken = 1'b1;
          if (c == "." && mode_r == M_DOT1) begin
            tlen_nxt = LENGTH_WIDTH'(2); mode_nxt = M_DOT2;
          end else if (c == ".") begin
            t = '0; t.kind = K_ELLIPS; t.start = tstart_r; t.len = LENGTH_WIDTH'(3);
            t.line = line_r; q[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
          end else begin
            t = '0; t.start = tstart_r; t.len = tlen_r; t.line = line_r; t.err = E_SYMBOL;
            q[n] = t; n = n + 1'b1; err = 1'b1; mode_nxt = M_IDLE;
          end
        end
        default: mode_nxt = M_IDLE;
      endcase

      // idle classification
      if (!taken && !err) begin
        if (is_alpha(c) || is_digit(c) || c == "/" || c == "-" || c == "=" || c == ".") begin
          mode_nxt = is_alpha(c) ? M_WORD : is_digit(c) ? M_INT : (c == "/") ? M_SLASH :
                     (c == "-") ? M_MINUS : (c == "=") ? M_EQ : M_DOT1;
          tstart_nxt = off_r; tlen_nxt = LENGTH_WIDTH'(1); pfx_nxt = {40'd0, c};
        end else if (is_space(c)) begin
          if (c == 8'h0a) line_nxt = line_r + 1'b1;
        end else begin
          case (c)
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            ":": k = K_COLON;
            ";": k = K_SEMI;
            "+": k = K_PLUS;
            "*": k = K_STAR;
            "%": k = K_PCT;
            ",": k = K_COMMA;
            default: k = K_END;
          endcase
          t = '0; t.start = off_r; t.len = LENGTH_WIDTH'(1); t.line = line_r;
          if (k == K_END) begin
            t.err = (c == ">") ? E_SYMBOL : E_CHAR; err = 1'b1;
          end else begin
            t.kind = k;
          end
          q[n] = t; n = n + 1'b1;
        end
      end

      off_nxt = off_inc;

      if (last) begin
        if (!err) begin
          // flush the held construct, using the post-character state
          t = '0; t.start = tstart_nxt; t.len = tlen_nxt; t.line = line_nxt;
          wk = kw(pfx_nxt, tlen_nxt);
          case (mode_nxt)
            M_WORD: begin t.kind = wk[8:4]; t.btype = wk[3:0]; q[n] = t; n = n + 1'b1; end
            M_INT: begin t.kind = K_INT; q[n] = t; n = n + 1'b1; end
            M_FRAC: begin t.kind = K_FLOAT; q[n] = t; n = n + 1'b1; end
            M_SLASH: begin t.kind = K_SLASH; q[n] = t; n = n + 1'b1; end
            M_MINUS: begin t.kind = K_MINUS; q[n] = t; n = n + 1'b1; end
            M_EQ: begin t.kind = K_ASSIGN; q[n] = t; n = n + 1'b1; end
            M_INTDOT: begin t.err = E_NODIG; q[n] = t; n = n + 1'b1; err = 1'b1; end
            M_DOT1, M_DOT2: begin t.err = E_SYMBOL; q[n] = t; n = n + 1'b1; err = 1'b1; end
            default: ;
          endcase
          if (!err) begin
            t = '0; t.kind = K_END; t.start = off_inc; t.line = '1;
            q[n] = t; n = n + 1'b1;
          end
        end
        halt_nxt = 1'b0;
        mode_nxt = M_IDLE; off_nxt = '0; line_nxt = LINE_WIDTH'(1);
        tstart_nxt = '0; tlen_nxt = '0; pfx_nxt = '0;
      end else if (err) begin
        halt_nxt = 1'b1; mode_nxt = M_IDLE;
      end
    end

    if (n != 2'd0) q[n - 1'b1].fin = 1'b1;
    grp.cnt = n;
    grp.t0 = q[0];
    grp.t1 = q[1];
    grp.t2 = q[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; off_r <= '0; line_r <= LINE_WIDTH'(1);
      tstart_r <= '0; tlen_r <= '0; pfx_r <= '0; halt_r <= 1'b0;
    end else if (go) begin
      mode_r <= mode_nxt; off_r <= off_nxt; line_r <= line_nxt;
      tstart_r <= tstart_nxt; tlen_r <= tlen_nxt; pfx_r <= pfx_nxt; halt_r <= halt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/slex_queue.sv =====
// small queue of result groups between front and back
`default_nettype none
module slex_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire slex_pkg::group_t wdata,
  input  wire logic             pop,
  output slex_pkg::group_t      rdata,
  output logic                  empty,
  output logic                  full
);
  import slex_pkg::*;

  group_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/slex_back.sv =====
// back end: unrolls each group into single result words on a register
`default_nettype none
module slex_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire slex_pkg::group_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output slex_pkg::tok_t        out_tok
);
  import slex_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r;
  tok_t       tok_r;
  logic       load;
  tok_t       cur;

  assign out_valid = vld_r;
  assign out_tok   = tok_r;
  assign load      = !vld_r || !out_stall;

  always_comb begin
    case (idx_r)
      2'd0: cur = q_data.t0;
      2'd1: cur = q_data.t1;
      default: cur = q_data.t2;
    endcase
    q_pop   = 1'b0;
    idx_nxt = idx_r;
    if (load && !q_empty) begin
      if (idx_r + 1'b1 >= q_data.cnt) begin
        q_pop = 1'b1; idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0; idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) vld_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) tok_r <= cur;
  end

endmodule
`default_nettype wire

// ===== sv/source_lexer_core.sv =====
// top level of the source lexer
// input channel: in_valid/in_stall carry one source byte and an end-of-text flag
// output channel: out_valid/out_stall carry one token word per handshake
// a byte is taken and classified at once; bytes that make
// results push a group of up to three words into a four-entry queue
// the back end hands out one word per cycle from a registered output while out_stall is low
// a byte's first word is written to a queue entry and from there to the output register
// sustained rate is one byte per cycle while words drain at least as
// fast as they are made; a byte that gives three words hands them out one
// after another, and in_stall rises when the queue is full
// at reset the lexer is between tokens at offset zero, line one
// a stalled receiver holds the output word and backs up into the queue
`default_nettype none
module source_lexer_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [7:0]                           in_source_char,
  input  wire logic                                 in_end_of_text,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [4:0]                                out_token_kind,
  output logic [3:0]                                out_builtin_kind,
  output logic [slex_pkg::OFFSET_WIDTH-1:0]         out_start_offset,
  output logic [slex_pkg::LENGTH_WIDTH-1:0]         out_token_length,
  output logic [slex_pkg::LINE_WIDTH-1:0]           out_line_number,
  output logic [1:0]                                out_error_code,
  output logic                                      out_final_result
);
  import slex_pkg::*;

  group_t grp, q_data;
  tok_t   tok;
  logic   go, q_empty, q_full, q_pop;

  assign in_stall = q_full;
  assign go       = in_valid && !q_full;

  slex_front u_front (
    .clk(clk), .rst_n(rst_n), .go(go), .c(in_source_char),
    .last(in_end_of_text), .grp(grp)
  );

  slex_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(go && grp.cnt != 2'd0), .wdata(grp),
    .pop(q_pop), .rdata(q_data), .empty(q_empty), .full(q_full)
  );

  slex_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_tok(tok)
  );

  assign out_token_kind   = tok.kind;
  assign out_builtin_kind = tok.btype;
  assign out_start_offset = tok.start;
  assign out_token_length = tok.len;
  assign out_line_number  = tok.line;
  assign out_error_code   = tok.err;
  assign out_final_result = tok.fin;

endmodule
`default_nettype wire

// ===== sv/slex_checker.sv =====
// port-level checks for the source lexer, bound to the top level
`default_nettype none
module slex_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [4:0] out_token_kind,
  input wire logic [1:0] out_error_code,
  input wire logic       out_final_result
);
  import slex_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind))
    else $error("output word changed under stall");
  a_err_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != E_NONE |-> out_final_result)
    else $error("error word not last of its group");
  a_end_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_END |-> out_final_result && out_error_code == E_NONE)
    else $error("end token malformed");
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != E_NONE |-> out_token_kind == K_IDENT)
    else $error("error word with token kind");
endmodule

bind source_lexer_core slex_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_token_kind(out_token_kind), .out_error_code(out_error_code),
  .out_final_result(out_final_result)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for source_lexer_core: streams program text, predicts tokens and checks each word
`default_nettype none
module tb;
  import slex_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_source_char = 8'h00;
  logic in_end_of_text = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] out_token_kind;
  logic [3:0] out_builtin_kind;
  logic [OFFSET_WIDTH-1:0] out_start_offset;
  logic [LENGTH_WIDTH-1:0] out_token_length;
  logic [LINE_WIDTH-1:0] out_line_number;
  logic [1:0] out_error_code;
  logic out_final_result;

  source_lexer_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_source_char(in_source_char), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_builtin_kind(out_builtin_kind),
    .out_start_offset(out_start_offset), .out_token_length(out_token_length),
    .out_line_number(out_line_number), .out_error_code(out_error_code),
    .out_final_result(out_final_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tok_t token_q[$];
  int fail_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  // lexer state for prediction
  mode_t lx_mode;
  logic [OFFSET_WIDTH-1:0] lx_offset;
  logic [LINE_WIDTH-1:0] lx_line;
  logic [OFFSET_WIDTH-1:0] lx_start;
  logic [LENGTH_WIDTH-1:0] lx_len;
  logic [47:0] lx_prefix;
  bit lx_halted;
  tok_t pend[$];

  string kw_text[17] = '{"return", "let", "fn", "extern", "void", "i8", "i16", "i32",
    "i64", "i128", "u8", "u16", "u32", "u64", "u128", "f32", "f64"};

  function automatic void lex_clear();
    lx_mode = M_IDLE;
    lx_offset = '0;
    lx_line = 1;
    lx_start = '0;
    lx_len = '0;
    lx_prefix = '0;
    lx_halted = 1'b0;
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void push_tok(logic [4:0] k, logic [3:0] b, logic [OFFSET_WIDTH-1:0] s,
                                   logic [LENGTH_WIDTH-1:0] l, logic [LINE_WIDTH-1:0] ln,
                                   logic [1:0] e);
    tok_t t;
    t.kind = k; t.btype = b; t.start = s; t.len = l; t.line = ln; t.err = e; t.fin = 1'b0;
    pend = {pend, t};
  endfunction

  function automatic void raise_err(logic [OFFSET_WIDTH-1:0] s, logic [LENGTH_WIDTH-1:0] l,
                                    logic [1:0] e);
    push_tok(K_IDENT, 4'd0, s, l, lx_line, e);
    lx_halted = 1'b1;
    lx_mode = M_IDLE;
  endfunction

  function automatic void emit_held(logic [4:0] k);
    push_tok(k, 4'd0, lx_start, lx_len, lx_line, E_NONE);
  endfunction

  function automatic void emit_word();
    logic [47:0] p;
    if (lx_len <= 6) begin
      for (int i = 0; i < 17; i++) begin
        p = '0;
        for (int k = 0; k < kw_text[i].len(); k++) p = (p << 8) | kw_text[i][k];
        if (kw_text[i].len() == lx_len && p == lx_prefix) begin
          if (i < 4) push_tok(5'(K_RETURN + i), 4'd0, lx_start, lx_len, lx_line, E_NONE);
          else push_tok(K_BUILTIN, 4'(i - 4), lx_start, lx_len, lx_line, E_NONE);
          return;
        end
      end
    end
    emit_held(K_IDENT);
  endfunction

  function automatic void open_tok(mode_t m, logic [7:0] c);
    lx_mode = m; lx_start = lx_offset; lx_len = 1; lx_prefix = c;
  endfunction

  function automatic logic [LENGTH_WIDTH-1:0] grow(logic [LENGTH_WIDTH-1:0] n);
    return (&n) ? n : n + 1'b1;
  endfunction

  function automatic void start_fresh(logic [7:0] c);
    logic [4:0] k;
    if (alpha(c)) begin open_tok(M_WORD, c); return; end
    if (digit(c)) begin open_tok(M_INT, c); return; end
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      if (c == 8'd10) lx_line++;
      return;
    end
    case (c)
      "/": begin open_tok(M_SLASH, c); return; end
      "-": begin open_tok(M_MINUS, c); return; end
      "=": begin open_tok(M_EQ, c); return; end
      ".": begin open_tok(M_DOT1, c); return; end
      ">": begin raise_err(lx_offset, 1, E_SYMBOL); return; end
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ":": k = K_COLON;
      ";": k = K_SEMI;
      "+": k = K_PLUS;
      "*": k = K_STAR;
      "%": k = K_PCT;
      ",": k = K_COMMA;
      default: begin raise_err(lx_offset, 1, E_CHAR); return; end
    endcase
    push_tok(k, 4'd0, lx_offset, 1, lx_line, E_NONE);
  endfunction

  // returns 1 when the byte was consumed by the pending construct
  function automatic bit extend_tok(logic [7:0] c);
    case (lx_mode)
      M_WORD: begin
        if (alpha(c) || digit(c)) begin
          if (lx_len < 6) lx_prefix = (lx_prefix << 8) | c;
          lx_len = grow(lx_len);
          return 1;
        end
        emit_word();
      end
      M_INT: begin
        if (digit(c)) begin lx_len = grow(lx_len); return 1; end
        if (c == ".") begin lx_len = grow(lx_len); lx_mode = M_INTDOT; return 1; end
        emit_held(K_INT);
      end
      M_INTDOT: begin
        if (digit(c)) begin lx_len = grow(lx_len); lx_mode = M_FRAC; return 1; end
        raise_err(lx_start, lx_len, E_NODIG);
        return 1;
      end
      M_FRAC: begin
        if (digit(c)) begin lx_len = grow(lx_len); return 1; end
        emit_held(K_FLOAT);
      end
      M_SLASH: begin
        if (c == "/") begin lx_mode = M_LINECMT; return 1; end
        if (c == "*") begin lx_mode = M_BLOCKSTAR; return 1; end
        emit_held(K_SLASH);
      end
      M_LINECMT: begin
        if (c == 8'd10) begin lx_line++; lx_mode = M_IDLE; end
        return 1;
      end
      M_BLOCK, M_BLOCKSTAR: begin
        if (lx_mode == M_BLOCKSTAR && c == "/") lx_mode = M_IDLE;
        else if (c == "*") lx_mode = M_BLOCKSTAR;
        else begin
          if (c == 8'd10) lx_line++;
          lx_mode = M_BLOCK;
        end
        return 1;
      end
      M_MINUS: begin
        if (c == ">") begin
          push_tok(K_ARROW, 4'd0, lx_start, 2, lx_line, E_NONE);
          lx_mode = M_IDLE;
          return 1;
        end
        emit_held(K_MINUS);
      end
      M_EQ: begin
        if (c == "=") begin
          push_tok(K_EQEQ, 4'd0, lx_start, 2, lx_line, E_NONE);
          lx_mode = M_IDLE;
          return 1;
        end
        emit_held(K_ASSIGN);
      end
      M_DOT1: begin
        if (c == ".") begin lx_len = 2; lx_mode = M_DOT2; return 1; end
        raise_err(lx_start, lx_len, E_SYMBOL);
        return 1;
      end
      M_DOT2: begin
        if (c == ".") begin
          push_tok(K_ELLIPS, 4'd0, lx_start, 3, lx_line, E_NONE);
          lx_mode = M_IDLE;
          return 1;
        end
        raise_err(lx_start, lx_len, E_SYMBOL);
        return 1;
      end
      default: begin lx_mode = M_IDLE; return 0; end
    endcase
    lx_mode = M_IDLE;
    return 0;
  endfunction

  function automatic void flush_tok();
    case (lx_mode)
      M_WORD: emit_word();
      M_INT: emit_held(K_INT);
      M_FRAC: emit_held(K_FLOAT);
      M_SLASH: emit_held(K_SLASH);
      M_MINUS: emit_held(K_MINUS);
      M_EQ: emit_held(K_ASSIGN);
      M_INTDOT: raise_err(lx_start, lx_len, E_NODIG);
      M_DOT1, M_DOT2: raise_err(lx_start, lx_len, E_SYMBOL);
      default: ;
    endcase
    lx_mode = M_IDLE;
  endfunction

  function automatic void predict_tokens(logic [7:0] c, bit last);
    pend.delete();
    if (lx_halted) begin
      if (last) lex_clear();
      return;
    end
    if (!extend_tok(c) && !lx_halted) start_fresh(c);
    lx_offset++;
    if (last) begin
      if (!lx_halted) begin
        flush_tok();
        if (!lx_halted) push_tok(K_END, 4'd0, lx_offset, 0, '1, E_NONE);
      end
      lex_clear();
    end
    if (pend.size() > 0) pend[pend.size()-1].fin = 1'b1;
    token_q = {token_q, pend};
  endfunction

  task automatic send_char(logic [7:0] c, bit last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_char <= c;
    in_end_of_text <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(c, last);
  endtask

  task automatic send_text(string s, bit last);
    foreach (s[i]) send_char(s[i], last && i == s.len() - 1);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    tok_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $error("unexpected word kind=%0d", out_token_kind);
        fail_count++;
      end else begin
        w = token_q.pop_front();
        if (out_token_kind !== w.kind) begin
          $error("token_kind exp %0d got %0d", w.kind, out_token_kind); fail_count++;
        end
        if (out_builtin_kind !== w.btype) begin
          $error("builtin_kind exp %0d got %0d", w.btype, out_builtin_kind); fail_count++;
        end
        if (out_start_offset !== w.start) begin
          $error("start_offset exp %0d got %0d", w.start, out_start_offset); fail_count++;
        end
        if (out_token_length !== w.len) begin
          $error("token_length exp %0d got %0d", w.len, out_token_length); fail_count++;
        end
        if (out_line_number !== w.line) begin
          $error("line_number exp %0h got %0h", w.line, out_line_number); fail_count++;
        end
        if (out_error_code !== w.err) begin
          $error("error_code exp %0d got %0d", w.err, out_error_code); fail_count++;
        end
        if (out_final_result !== w.fin) begin
          $error("final_result exp %0d got %0d", w.fin, out_final_result); fail_count++;
        end
      end
    end
  end

  task automatic test_keywords();
    send_text("return let fn extern void i8 i16 i32 i64 i128 u8 u16 u32 u64 u128 f32 f64",
              0);
    send_text(" Zq9abcdefgh", 1);
  endtask

  task automatic test_numbers_symbols();
    send_text("0 9.5 12.340(){}:;=+==-->*/%...,\n", 0);
    send_text("a/", 1);
  endtask

  task automatic test_comments();
    send_text("// c\nx/* a\n*/y/*/z\t/* q", 1);
    send_text("// open", 1);
  endtask

  task automatic test_errors();
    send_text("1.x ab", 1);
    send_text(".a", 1);
    send_text("..b", 1);
    send_text(">", 1);
    send_char(8'hff, 0);
    send_text("k", 1);
    send_text("3.", 1);
  endtask

  task automatic test_random();
    string frags[20] = '{"let ", "fn ", "return", "i128", "u64", "f32", "abc", "x1y2",
      "42", "3.14", "(", ")", "{}", "->", "==", "=", "...", "// n\n", "/* b */", "\n"};
    string f;
    int n;
    n = 0;
    while (n < 60) begin
      if ($urandom_range(0, 9) < 8) begin
        f = frags[$urandom_range(0, 19)];
        send_text(f, 0);
        send_char(" ", $urandom_range(0, 15) == 0);
        n += f.len() + 1;
      end else begin
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        n++;
      end
      if (n > 40) idle_on = 1'b0;
    end
    send_text("end", 1);
  endtask

  initial begin
    lex_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_keywords();
    test_numbers_symbols();
    test_comments();
    test_errors();
    test_random();
    in_valid <= 1'b0;
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/slex_pkg.sv
sv/slex_front.sv
sv/slex_queue.sv
sv/slex_back.sv
sv/source_lexer_core.sv
sv/slex_checker.sv
tb/sv/tb.sv
